@@ hw/rtl/stq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg
// Shared constants for the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;
  localparam int NumTimersDef = 16;
  localparam int TickBitsDef  = 32;
  localparam int ItemBits     = 71;
  localparam int OutBits      = 40;

  localparam logic [1:0] FUNC_START    = 2'd0;
  localparam logic [1:0] FUNC_DELETE   = 2'd1;
  localparam logic [1:0] FUNC_ANNOUNCE = 2'd2;

  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;
endpackage
`default_nettype wire

@@ hw/rtl/stq_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stq_front
// Accepts input transfers and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module stq_front
  import stq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [ItemBits-1:0] in_item,
  output logic                     q_valid,
  input  wire logic                q_ready,
  output logic [ItemBits-1:0]      q_item
);
  logic [ItemBits-1:0] mem_r [2];
  logic                wp_r, rp_r;
  logic [1:0]          cnt_r;
  logic                push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/stq_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stq_engine
// Carries out start, delete and announce on the ordered slot list.
// ----------------------------------------------------------------------------
module stq_engine
  import stq_pkg::*;
#(
  parameter int NUM_TIMERS = NumTimersDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire logic [ItemBits-1:0] q_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [OutBits-1:0]       out_data
);
  localparam int TICK_BITS = TickBitsDef;
  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam logic [TICK_BITS-1:0] NO_TIMER_TICKS = {TICK_BITS{1'b1}};

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DISP   = 4'd1;
  localparam logic [3:0] ST_REMOVE = 4'd2;
  localparam logic [3:0] ST_FIND   = 4'd3;
  localparam logic [3:0] ST_INSERT = 4'd4;
  localparam logic [3:0] ST_FLUSH  = 4'd5;
  localparam logic [3:0] ST_RESTRT = 4'd6;
  localparam logic [3:0] ST_EXPIRE = 4'd7;
  localparam logic [3:0] ST_EMIT   = 4'd8;
  localparam logic [3:0] ST_STATUS = 4'd9;

  localparam logic [1:0] RET_DISP  = 2'd0;
  localparam logic [1:0] RET_FLUSH = 2'd1;
  localparam logic [1:0] RET_EXP   = 2'd2;

  logic [3:0]           st_r;
  logic [NUM_TIMERS-1:0] act_r, era_r, per_r;
  logic [TICK_BITS-1:0] tmo_r [NUM_TIMERS];
  logic [TICK_BITS-1:0] prd_r [NUM_TIMERS];
  logic [IW-1:0]        ord_r [NUM_TIMERS];
  logic [IW-1:0]        fl_r  [NUM_TIMERS];
  logic [CW-1:0]        cnt_r, nf_r, fi_r, ri_r, pos_r, n_r;
  logic                 wrap_r;
  logic [TICK_BITS-1:0] prev_r, cur_r, ntmo_r;
  logic [1:0]           func_r, ret_r;
  logic [IW-1:0]        sid_r;
  logic                 nera_r, idok_r, hit_r;
  logic                 ov_r;
  logic [OutBits-1:0]   od_r;

  logic [3:0]            tid;
  logic [IW-1:0]         head;
  logic                  cur_empty;
  logic [TICK_BITS-1:0]  p_eff, sum;
  logic [TICK_BITS-1:0]  htmo;
  logic [TICK_BITS-1:0]  nt;
  logic [IW-1:0]         ordk;
  logic                  kgt;

  assign tid       = q_item[5:2];
  assign head      = ord_r[0];
  assign cur_empty = (cnt_r == '0) || era_r[head];
  assign htmo      = tmo_r[head];
  assign p_eff     = (prd_r[sid_r] == '0) ? {{(TICK_BITS-1){1'b0}}, 1'b1} : prd_r[sid_r];
  assign sum       = cur_r + p_eff;
  assign ordk      = ord_r[pos_r[IW-1:0]];
  assign kgt       = (era_r[ordk] != nera_r) ? era_r[ordk] : (tmo_r[ordk] > ntmo_r);
  assign q_ready   = (st_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    if (cnt_r == '0 || (cur_empty && !wrap_r)) begin
      nt = NO_TIMER_TICKS;
    end else if (htmo <= cur_r) begin
      nt = wrap_r ? (htmo - cur_r) : '0;
    end else begin
      nt = htmo - cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      act_r  <= '0;
      era_r  <= '0;
      cnt_r  <= '0;
      wrap_r <= 1'b0;
      prev_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (ov_r && out_ready) begin
        ov_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (q_valid) begin
            func_r <= q_item[1:0];
            idok_r <= ({28'd0, tid} < NUM_TIMERS);
            sid_r  <= IW'(tid);
            cur_r  <= q_item[70:39];
            n_r    <= '0;
            if (q_item[1:0] == FUNC_START && {28'd0, tid} < NUM_TIMERS) begin
              prd_r[IW'(tid)] <= q_item[37:6];
              per_r[IW'(tid)] <= q_item[38];
            end
            st_r <= ST_DISP;
          end
        end
        ST_DISP: begin
          ret_r <= RET_DISP;
          if (func_r == FUNC_START && idok_r) begin
            pos_r <= '0;
            hit_r <= 1'b0;
            st_r  <= ST_REMOVE;
          end else if (func_r == FUNC_DELETE && idok_r) begin
            pos_r <= '0;
            hit_r <= 1'b0;
            st_r  <= ST_REMOVE;
          end else if (func_r == FUNC_ANNOUNCE) begin
            nf_r <= '0;
            st_r <= (cur_r < prev_r) ? ST_FLUSH : ST_EXPIRE;
          end else begin
            st_r <= ST_STATUS;
          end
        end
        ST_REMOVE: begin
          // Walks the list, shifting entries after sid_r down by one.
          if (!act_r[sid_r] || pos_r >= cnt_r) begin
            if (act_r[sid_r]) begin
              cnt_r <= cnt_r - 1'b1;
            end
            act_r[sid_r] <= 1'b0;
            era_r[sid_r] <= 1'b0;
            if (func_r == FUNC_DELETE) begin
              st_r <= ST_STATUS;
            end else begin
              ntmo_r <= sum;
              nera_r <= (sum < cur_r);
              pos_r  <= '0;
              st_r   <= ST_FIND;
            end
          end else begin
            if (hit_r || ordk == sid_r) begin
              hit_r <= 1'b1;
              if (pos_r + 1'b1 < cnt_r) begin
                ord_r[pos_r[IW-1:0]] <= ord_r[pos_r[IW-1:0] + 1'b1];
              end
            end
            pos_r <= pos_r + 1'b1;
          end
        end
        ST_FIND: begin
          if (pos_r < cnt_r && !kgt) begin
            pos_r <= pos_r + 1'b1;
          end else if (cnt_r >= CW'(NUM_TIMERS)) begin
            st_r <= ST_STATUS;
          end else begin
            fi_r  <= cnt_r;
            st_r  <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          if (fi_r > pos_r) begin
            ord_r[fi_r[IW-1:0]] <= ord_r[fi_r[IW-1:0] - 1'b1];
            fi_r <= fi_r - 1'b1;
          end else begin
            ord_r[pos_r[IW-1:0]] <= sid_r;
            cnt_r         <= cnt_r + 1'b1;
            act_r[sid_r]  <= 1'b1;
            era_r[sid_r]  <= nera_r;
            tmo_r[sid_r]  <= ntmo_r;
            if (nera_r) begin
              wrap_r <= 1'b1;
            end
            case (ret_r)
              RET_FLUSH: st_r <= ST_RESTRT;
              RET_EXP:   st_r <= ST_EXPIRE;
              default:   st_r <= ST_STATUS;
            endcase
          end
        end
        ST_FLUSH: begin
          if (!ov_r) begin
            if (!cur_empty) begin
              ov_r <= 1'b1;
              od_r <= {1'b0, 32'd0, 4'(head), KIND_EXPIRED, 2'b00};
              n_r  <= n_r + 1'b1;
              if (per_r[head]) begin
                fl_r[nf_r[IW-1:0]] <= head;
                nf_r <= nf_r + 1'b1;
              end
              act_r[head] <= 1'b0;
              era_r[head] <= 1'b0;
              for (int i = 0; i < NUM_TIMERS - 1; i++) begin
                ord_r[i] <= ord_r[i + 1];
              end
              cnt_r <= cnt_r - 1'b1;
            end else begin
              if (wrap_r) begin
                era_r  <= '0;
                wrap_r <= 1'b0;
              end
              ri_r <= '0;
              st_r <= ST_RESTRT;
            end
          end
        end
        ST_RESTRT: begin
          if (ri_r < nf_r) begin
            sid_r <= fl_r[ri_r[IW-1:0]];
            ri_r  <= ri_r + 1'b1;
            ret_r <= RET_FLUSH;
            st_r  <= ST_EMIT;
          end else begin
            st_r <= ST_EXPIRE;
          end
        end
        ST_EMIT: begin
          // Restart sid_r: it is idle here, so go straight to the search.
          ntmo_r <= sum;
          nera_r <= (sum < cur_r);
          pos_r  <= '0;
          prev_r <= cur_r;
          st_r   <= ST_FIND;
        end
        ST_EXPIRE: begin
          if (!ov_r) begin
            if (!cur_empty && htmo <= cur_r && n_r < CW'(NUM_TIMERS)) begin
              ov_r <= 1'b1;
              od_r <= {1'b0, 32'd0, 4'(head), KIND_EXPIRED, 2'b00};
              n_r  <= n_r + 1'b1;
              act_r[head] <= 1'b0;
              era_r[head] <= 1'b0;
              for (int i = 0; i < NUM_TIMERS - 1; i++) begin
                ord_r[i] <= ord_r[i + 1];
              end
              cnt_r <= cnt_r - 1'b1;
              if (per_r[head]) begin
                sid_r <= head;
                ret_r <= RET_EXP;
                st_r  <= ST_EMIT;
              end
            end else begin
              prev_r <= cur_r;
              st_r   <= ST_STATUS;
            end
          end
        end
        ST_STATUS: begin
          if (func_r == FUNC_START && idok_r && ret_r == RET_DISP) begin
            prev_r <= cur_r;
          end
          if (func_r == FUNC_DELETE && idok_r && wrap_r && cur_empty) begin
            era_r  <= '0;
            wrap_r <= 1'b0;
          end else if (!ov_r) begin
            ov_r <= 1'b1;
            od_r <= {1'b1, 32'(nt), 4'd0, KIND_STATUS, 2'b00};
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/sorted_timer_queue_with_wrap.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timer_queue_with_wrap
// Timer slots kept in expiry order, with tick wrap handling.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata fields (low bit first)
// in_      slave      func, timer_id, period, periodic, now_tick
// out_     master     kind, expired_id, next_ticks; tlast marks the status
// The ordered list is walked one entry per cycle. A start walks it to remove
// the slot and again to find its place; a delete walks it to remove the slot.
// An announce emits each expiry as its own result, and each periodic
// restart adds a search of the list.
// Each result waits in one output register while out_tready is low, which
// stalls the engine; a two-entry queue takes new transfers meanwhile.
// Reset is synchronous and needs no clearing pass.
module sorted_timer_queue_with_wrap
  import stq_pkg::*;
#(
  parameter int NUM_TIMERS = NumTimersDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,  // func, timer_id, period, periodic, now_tick
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata, // kind, expired_id, next_ticks
  output logic             out_tlast
);
  logic                q_valid, q_ready;
  logic [ItemBits-1:0] q_item;
  logic [OutBits-1:0]  od;

  stq_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_item(in_tdata[ItemBits-1:0]), .q_valid(q_valid), .q_ready(q_ready),
    .q_item(q_item)
  );

  stq_engine #(.NUM_TIMERS(NUM_TIMERS)) u_engine (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_item(q_item), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_data(od)
  );

  assign out_tdata = {3'd0, od[38:2]};
  assign out_tlast = od[39] & ~od[1] & ~od[0] | od[39] & (od[1] | od[0]);
endmodule
`default_nettype wire
